// ----- hdl/dit_pkg.sv -----
// Shared types and constants for the dense identifier interning table.
`timescale 1ns / 1ps
`default_nettype none
package dit_pkg;

	localparam int ID_W          = 8;
	localparam int HALF_W        = 32;
	localparam int KEY_W         = 66;
	localparam int KIND_W        = 2;
	localparam int PATH_W        = 64;
	localparam int GLOB_KEY_W    = 2 * HALF_W;
	localparam int CNT_OUT_W     = 7;
	localparam int CNT_OUT_MAX   = 127;
	localparam int FILE_DEPTH_DEF = 64;
	localparam int GLOB_DEPTH_DEF = 64;

	localparam logic REQ_FILE = 1'b0;
	localparam logic REQ_GLOB = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} scan_state_t;

	typedef struct packed {
		logic            busy;
		logic            rd_en;
		logic            finish;
		logic            hit;
		logic [ID_W-1:0] hit_id;
	} scan_stat_t;

endpackage
`default_nettype wire

// ----- hdl/dit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/dit_scan.sv -----
// Scan sequencer: walks stored entries one at a time through a shared key comparator.
`timescale 1ns / 1ps
`default_nettype none
module dit_scan
	import dit_pkg::*;
#(
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire [CNT_W-1:0]   scan_cnt,
	input  wire [KEY_W-1:0]   req_key,
	input  wire [KEY_W-1:0]   rd_key,
	input  wire [ID_W-1:0]    rd_id,
	output logic [IDX_W-1:0]  rd_addr,
	output scan_stat_t        stat
);

	scan_state_t      state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic [ID_W-1:0]  hit_id_q;
	logic             key_eq;
	logic             last_entry;

	assign key_eq     = (rd_key == req_key);
	assign last_entry = ((CNT_W'(idx_q) + CNT_W'(1)) == scan_cnt);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (scan_cnt == '0) ? ST_DONE : ST_READ;
				end
			end
			ST_READ: state_d = ST_CMP;
			ST_CMP: begin
				if (key_eq || last_entry) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			hit_q    <= 1'b0;
			hit_id_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			if (state_q == ST_CMP) begin
				if (key_eq) begin
					hit_q    <= 1'b1;
					hit_id_q <= rd_id;
				end else if (!last_entry) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		rd_addr     = idx_q;
		stat.busy   = (state_q != ST_IDLE);
		stat.rd_en  = (state_q == ST_READ);
		stat.finish = (state_q == ST_DONE);
		stat.hit    = hit_q;
		stat.hit_id = hit_id_q;
	end

endmodule
`default_nettype wire

// ----- hdl/dense_id_intern_table.sv -----
// Top level of the dense identifier interning table: tables, counters, result register.
// Sequence: after accept the scan reads and compares entries of the addressed table,
//   a READ then a CMP state per entry, until a hit or its fill count is reached; then DONE.
// The result strobe is registered from DONE. A new request is taken only once busy drops;
//   all compares use the one shared key comparator. busy drops with the result strobe.
// Reset: fill counts clear, first_index and next_id return to 1; table RAMs are not cleared,
//   the fill counts alone mark which entries hold data. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module dense_id_intern_table
	import dit_pkg::*;
#(
	parameter int FILE_DEPTH = FILE_DEPTH_DEF,
	parameter int GLOB_DEPTH = GLOB_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// request channel
	input  wire                  start,
	output logic                 busy,
	input  wire                  req_type,
	input  wire [PATH_W-1:0]     path_id,
	input  wire [KIND_W-1:0]     path_kind,
	input  wire [HALF_W-1:0]     parent_index,
	input  wire [HALF_W-1:0]     glob_position,
	// configuration channel
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire                  cfg_data,
	// result channel
	output logic                 result_valid,
	output logic [ID_W-1:0]      source_index,
	output logic                 was_new,
	output logic                 table_full,
	output logic [CNT_OUT_W-1:0] file_entry_count
);

	// Sizing: index widths address the RAMs, count widths reach the full depth.
	localparam int FILE_IDX_W = $clog2(FILE_DEPTH);
	localparam int GLOB_IDX_W = $clog2(GLOB_DEPTH);
	localparam int FILE_CNT_W = $clog2(FILE_DEPTH + 1);
	localparam int GLOB_CNT_W = $clog2(GLOB_DEPTH + 1);
	localparam int IDX_W = (FILE_IDX_W > GLOB_IDX_W) ? FILE_IDX_W : GLOB_IDX_W;
	localparam int CNT_W = (FILE_CNT_W > GLOB_CNT_W) ? FILE_CNT_W : GLOB_CNT_W;
	localparam int FILE_WORD_W = ID_W + KIND_W + PATH_W;
	localparam int GLOB_WORD_W = ID_W + GLOB_KEY_W;

	logic                   accept;
	logic                   cfg_write;
	logic                   first_index_q;
	logic [ID_W-1:0]        next_id_q;
	logic [FILE_CNT_W-1:0]  file_cnt_q;
	logic [GLOB_CNT_W-1:0]  glob_cnt_q;

	logic                   req_type_q;
	logic [KEY_W-1:0]       req_key_q;
	logic [KEY_W-1:0]       in_key;
	logic                   sel_type;
	logic [CNT_W-1:0]       sel_cnt;

	scan_stat_t             stat;
	logic [IDX_W-1:0]       rd_addr;
	logic [FILE_WORD_W-1:0] file_rd;
	logic [GLOB_WORD_W-1:0] glob_rd;
	logic [KEY_W-1:0]       rd_key;
	logic [ID_W-1:0]        rd_id;

	logic                   file_full;
	logic                   glob_full;
	logic                   miss_full;
	logic                   do_insert;
	logic                   file_wr;
	logic                   glob_wr;
	logic [FILE_CNT_W-1:0]  file_cnt_new;
	logic [31:0]            file_cnt_wide;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// File key is the kind above the path; glob key packs parent above position.
	always_comb begin
		if (req_type == REQ_GLOB) begin
			in_key = {{KIND_W{1'b0}}, parent_index, glob_position};
		end else begin
			in_key = {path_kind, path_id};
		end
	end

	// The sequencer samples the fill count of the table the request addresses:
	// the incoming type at accept, the held type during the scan.
	assign sel_type = busy ? req_type_q : req_type;
	assign sel_cnt  = (sel_type == REQ_GLOB) ? CNT_W'(glob_cnt_q) : CNT_W'(file_cnt_q);

	// Hold the request for the whole scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			req_key_q  <= in_key;
		end
	end

	dit_scan #(
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.scan_cnt (sel_cnt),
		.req_key  (req_key_q),
		.rd_key   (rd_key),
		.rd_id    (rd_id),
		.rd_addr  (rd_addr),
		.stat     (stat)
	);

	assign busy = stat.busy;

	// Insert decision, taken in the single finishing cycle of a scan.
	assign file_full = (FILE_CNT_W'(FILE_DEPTH) == file_cnt_q);
	assign glob_full = (GLOB_CNT_W'(GLOB_DEPTH) == glob_cnt_q);
	assign miss_full = (req_type_q == REQ_GLOB) ? glob_full : file_full;
	assign do_insert = stat.finish && !stat.hit && !miss_full;
	assign file_wr   = do_insert && (req_type_q == REQ_FILE);
	assign glob_wr   = do_insert && (req_type_q == REQ_GLOB);

	// Entries are never removed, so the first free slot is always the fill count.
	dit_ram #(
		.WIDTH (FILE_WORD_W),
		.DEPTH (FILE_DEPTH)
	) u_file_ram (
		.clk     (clk),
		.wr_en   (file_wr),
		.wr_addr (file_cnt_q[FILE_IDX_W-1:0]),
		.wr_data ({next_id_q, req_key_q}),
		.rd_en   (stat.rd_en && (req_type_q == REQ_FILE)),
		.rd_addr (rd_addr[FILE_IDX_W-1:0]),
		.rd_data (file_rd)
	);

	dit_ram #(
		.WIDTH (GLOB_WORD_W),
		.DEPTH (GLOB_DEPTH)
	) u_glob_ram (
		.clk     (clk),
		.wr_en   (glob_wr),
		.wr_addr (glob_cnt_q[GLOB_IDX_W-1:0]),
		.wr_data ({next_id_q, req_key_q[GLOB_KEY_W-1:0]}),
		.rd_en   (stat.rd_en && (req_type_q == REQ_GLOB)),
		.rd_addr (rd_addr[GLOB_IDX_W-1:0]),
		.rd_data (glob_rd)
	);

	// Steer the read word of the addressed table into the shared comparator.
	always_comb begin
		if (req_type_q == REQ_GLOB) begin
			rd_key = {{KIND_W{1'b0}}, glob_rd[GLOB_KEY_W-1:0]};
			rd_id  = glob_rd[GLOB_WORD_W-1 -: ID_W];
		end else begin
			rd_key = file_rd[KEY_W-1:0];
			rd_id  = file_rd[FILE_WORD_W-1 -: ID_W];
		end
	end

	// Count reported after this request; saturate at the port's range.
	assign file_cnt_new  = file_wr ? (file_cnt_q + FILE_CNT_W'(1)) : file_cnt_q;
	assign file_cnt_wide = 32'(file_cnt_new);

	// Counters and the configuration register. A first_index write reloads next_id
	// only while both tables are still empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_index_q <= 1'b1;
			next_id_q     <= ID_W'(1);
			file_cnt_q    <= '0;
			glob_cnt_q    <= '0;
		end else begin
			if (cfg_write) begin
				first_index_q <= cfg_data;
				if (file_cnt_q == '0 && glob_cnt_q == '0) begin
					next_id_q <= ID_W'(cfg_data);
				end
			end
			if (do_insert) begin
				next_id_q <= next_id_q + ID_W'(1);
			end
			if (file_wr) begin
				file_cnt_q <= file_cnt_q + FILE_CNT_W'(1);
			end
			if (glob_wr) begin
				glob_cnt_q <= glob_cnt_q + GLOB_CNT_W'(1);
			end
		end
	end

	// Result beat: strobe for one cycle after the finishing cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= stat.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.finish) begin
			if (stat.hit) begin
				source_index <= stat.hit_id;
			end else if (miss_full) begin
				source_index <= '0;
			end else begin
				source_index <= next_id_q;
			end
			was_new    <= do_insert;
			table_full <= !stat.hit && miss_full;
			file_entry_count <= (file_cnt_wide > 32'(CNT_OUT_MAX)) ?
				CNT_OUT_W'(CNT_OUT_MAX) : file_cnt_wide[CNT_OUT_W-1:0];
		end
	end

	// Checks on the sequencing and the insert path.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	a_finish_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		stat.finish |=> result_valid && !busy)
		else $error("finishing cycle not followed by a result beat");

	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(was_new && table_full))
		else $error("result both new and full");

	a_new_id: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && was_new) |-> (source_index == $past(next_id_q)))
		else $error("new identifier differs from the counter value");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(file_cnt_q) <= 32'(FILE_DEPTH)) && (32'(glob_cnt_q) <= 32'(GLOB_DEPTH)))
		else $error("fill count beyond table depth");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for the dense identifier interning table: directed and random requests.
`timescale 1ns / 1ps
module tb_top;
	import dit_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_ITEMS    = 385;

	// One result beat as the block presents it.
	typedef struct packed {
		logic [ID_W-1:0]      source_index;
		logic                 was_new;
		logic                 table_full;
		logic [CNT_OUT_W-1:0] file_entry_count;
	} id_result_t;

	// Track both key tables and the shared counter; queue the answer each request must get.
	class intern_scoreboard;
		logic [PATH_W-1:0]     file_path_tab[$];
		logic [KIND_W-1:0]     file_kind_tab[$];
		logic [ID_W-1:0]       file_id_tab[$];
		logic [GLOB_KEY_W-1:0] glob_key_tab[$];
		logic [ID_W-1:0]       glob_id_tab[$];
		bit                    first_index_reg;
		bit [ID_W-1:0]         next_id;
		id_result_t            expected_q[$];
		int                    errors;

		function new();
			first_index_reg = 1'b1;
			next_id = ID_W'(1);
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// The counter reloads only while both tables are still empty.
		function void set_first_index(bit value);
			first_index_reg = value;
			if (file_path_tab.size() == 0 && glob_key_tab.size() == 0)
				next_id = ID_W'(value);
		endfunction

		function void note_request(logic rtype, logic [PATH_W-1:0] path,
				logic [KIND_W-1:0] kind, logic [HALF_W-1:0] parent, logic [HALF_W-1:0] pos);
			id_result_t            want;
			logic [GLOB_KEY_W-1:0] key;
			bit                    found;
			want = '0;
			found = 1'b0;
			key = {parent, pos};
			if (rtype == REQ_FILE) begin
				foreach (file_path_tab[i])
					if (!found && file_path_tab[i] == path && file_kind_tab[i] == kind) begin
						want.source_index = file_id_tab[i];
						found = 1'b1;
					end
				if (!found) begin
					if (file_path_tab.size() >= FILE_DEPTH_DEF) begin
						want.table_full = 1'b1;
					end else begin
						file_path_tab.push_back(path);
						file_kind_tab.push_back(kind);
						file_id_tab.push_back(next_id);
						want.source_index = next_id;
						want.was_new = 1'b1;
						next_id++;
					end
				end
			end else begin
				foreach (glob_key_tab[i])
					if (!found && glob_key_tab[i] == key) begin
						want.source_index = glob_id_tab[i];
						found = 1'b1;
					end
				if (!found) begin
					if (glob_key_tab.size() >= GLOB_DEPTH_DEF) begin
						want.table_full = 1'b1;
					end else begin
						glob_key_tab.push_back(key);
						glob_id_tab.push_back(next_id);
						want.source_index = next_id;
						want.was_new = 1'b1;
						next_id++;
					end
				end
			end
			want.file_entry_count = CNT_OUT_W'((file_path_tab.size() > CNT_OUT_MAX) ?
				CNT_OUT_MAX : file_path_tab.size());
			expected_q.push_back(want);
		endfunction

		function void report(string field, longint unsigned want, logic [ID_W-1:0] got);
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		endfunction

		function void check_result(id_result_t got);
			id_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing outstanding, got index %0d",
					$time, got.source_index);
				return;
			end
			want = expected_q.pop_front();
			if (got.source_index !== want.source_index)
				report("source_index", want.source_index, got.source_index);
			if (got.was_new !== want.was_new)
				report("was_new", want.was_new, got.was_new);
			if (got.table_full !== want.table_full)
				report("table_full", want.table_full, got.table_full);
			if (got.file_entry_count !== want.file_entry_count)
				report("file_entry_count", want.file_entry_count, got.file_entry_count);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic req_type = REQ_FILE;
	logic [PATH_W-1:0] path_id = '0;
	logic [KIND_W-1:0] path_kind = '0;
	logic [HALF_W-1:0] parent_index = '0;
	logic [HALF_W-1:0] glob_position = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic res_valid;
	logic [ID_W-1:0] res_index;
	logic res_new;
	logic res_full;
	logic [CNT_OUT_W-1:0] res_count;

	intern_scoreboard sb;
	bit idle_on = 1'b1;
	int watchdog = 0;

	// Key pools: 20 paths x 4 kinds and 10 parents x 8 positions, 80 keys each, so both
	// tables fill up and then overflow while hits keep coming.
	logic [PATH_W-1:0] path_pool[20];
	logic [HALF_W-1:0] parent_pool[10];
	logic [HALF_W-1:0] pos_pool[8];

	always #5 clk = ~clk;

	dense_id_intern_table DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req_type         (req_type),
		.path_id          (path_id),
		.path_kind        (path_kind),
		.parent_index     (parent_index),
		.glob_position    (glob_position),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.result_valid     (res_valid),
		.source_index     (res_index),
		.was_new          (res_new),
		.table_full       (res_full),
		.file_entry_count (res_count)
	);

	// Take every result beat; the block shows it for one cycle only.
	always @(posedge clk) begin
		if (arst_n && res_valid)
			sb.check_result({res_index, res_new, res_full, res_count});
	end

	// Count cycles in which no beat moves on any channel; give up at the limit.
	always @(posedge clk) begin
		if ((start && !busy) || res_valid || (cfg_valid && cfg_ready))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("dense_id_intern_table: mismatch");
			$finish;
		end
	end

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (!idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Drop start and idle for the given number of cycles.
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Present one request, hold it until the block takes it, then maybe idle.
	task automatic send_req(input logic rtype, input logic [PATH_W-1:0] path,
			input logic [KIND_W-1:0] kind, input logic [HALF_W-1:0] parent,
			input logic [HALF_W-1:0] pos);
		int gap;
		req_type      <= rtype;
		path_id       <= path;
		path_kind     <= kind;
		parent_index  <= parent;
		glob_position <= pos;
		start         <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(rtype, path, kind, parent, pos);
		gap = pick_gap();
		if (gap > 0)
			hold_off(gap);
	endtask

	// Stop sending and wait until every outstanding result has arrived.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_first_index(input bit value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_first_index(value);
		cfg_valid <= 1'b0;
	endtask

	// Draw a request: mostly pooled keys with random content, the rest fresh random keys.
	// Fields that the request type ignores are drawn like the others, from the pools or at random.
	task automatic random_request();
		logic              rtype;
		logic [PATH_W-1:0] path;
		logic [KIND_W-1:0] kind;
		logic [HALF_W-1:0] parent;
		logic [HALF_W-1:0] pos;
		rtype  = $urandom_range(0, 1) ? REQ_GLOB : REQ_FILE;
		path   = {$urandom, $urandom};
		kind   = KIND_W'($urandom_range(0, 3));
		parent = $urandom;
		pos    = $urandom;
		if ($urandom_range(0, 99) < 80) begin
			path   = path_pool[$urandom_range(0, 19)];
			parent = parent_pool[$urandom_range(0, 9)];
			pos    = pos_pool[$urandom_range(0, 7)];
		end
		send_req(rtype, path, kind, parent, pos);
	endtask

	initial begin
		sb = new();
		foreach (path_pool[i])
			path_pool[i] = {$urandom, $urandom};
		foreach (parent_pool[i])
			parent_pool[i] = $urandom;
		foreach (pos_pool[i])
			pos_pool[i] = $urandom;
		// Neighboring keys that differ only across the 32-bit split.
		parent_pool[0] = '0;
		parent_pool[1] = '1;
		pos_pool[0] = '0;
		pos_pool[1] = '1;
		path_pool[0] = '0;
		path_pool[1] = '1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Both writes land while the tables are empty: the counter ends up at zero.
		write_first_index(1'b1);
		hold_off($urandom_range(1, 3));
		write_first_index(1'b0);

		// Directed: identifier zero, key extremes, kinds kept apart, hits with junk fields.
		send_req(REQ_FILE, '0, 2'd0, $urandom, $urandom);
		send_req(REQ_FILE, '1, 2'd3, $urandom, $urandom);
		send_req(REQ_FILE, '0, 2'd1, $urandom, $urandom);
		send_req(REQ_FILE, '0, 2'd2, $urandom, $urandom);
		send_req(REQ_FILE, '0, 2'd0, '1, '1);
		send_req(REQ_GLOB, {$urandom, $urandom}, KIND_W'($urandom_range(0, 3)), '0, '0);
		send_req(REQ_GLOB, {$urandom, $urandom}, KIND_W'($urandom_range(0, 3)), '1, '1);
		send_req(REQ_GLOB, {$urandom, $urandom}, KIND_W'($urandom_range(0, 3)), '0, 32'd1);
		send_req(REQ_GLOB, {$urandom, $urandom}, KIND_W'($urandom_range(0, 3)), 32'd1, '0);
		send_req(REQ_GLOB, '1, 2'd3, '0, '0);
		send_req(REQ_GLOB, '0, 2'd0, '1, '1);
		send_req(REQ_FILE, '1, 2'd3, '0, '0);
		send_req(REQ_FILE, '1, 2'd2, '1, '1);
		send_req(REQ_FILE, '1, 2'd1, $urandom, $urandom);

		// Late write: tables hold entries, so only the register changes.
		drain_results();
		write_first_index(1'b1);

		// Random phases; drain between them and flip the register while idle.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 100 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				random_request();
			end
			drain_results();
			write_first_index(phase[0]);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("dense_id_intern_table: match");
		else
			$display("dense_id_intern_table: mismatch");
		$finish;
	end

endmodule

// ----- dense_id_intern_table.f -----
hdl/dit_pkg.sv
hdl/dit_ram.sv
hdl/dit_scan.sv
hdl/dense_id_intern_table.sv
tb/tb_top.sv
